// ----- hdl/aprt_pkg.sv -----
// Package for the allowed prefix route table.
// Holds request and status codes and the cell control struct; no dependencies.
package aprt_pkg;

  localparam int AddrW = 64;
  localparam int LenW  = 8;
  localparam logic [LenW-1:0] FullLen = 8'd128;

  typedef enum logic [1:0] {
    REQ_ENABLE = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_ADD    = 2'd2,
    REQ_LOOKUP = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_NOROUTE = 2'd2
  } status_e;

  // Operation applied to a cell while the ring turns.
  typedef struct packed {
    logic shift;   // rotate data one cell along the chain
    logic clear;   // drop the used bit of the cell at the chain head
    logic write;   // load the head cell with the request
  } cell_ctrl_t;

  // Leading bits that two 128-bit values share (0..128).
  function automatic logic [LenW-1:0] common_lead(input logic [2*AddrW-1:0] a,
                                                  input logic [2*AddrW-1:0] b);
    logic [2*AddrW-1:0] x;
    logic [LenW-1:0]    n;
    logic               hit;
    x   = a ^ b;
    n   = FullLen;
    hit = 1'b0;
    for (int i = 2*AddrW-1; i >= 0; i--) begin
      if (x[i] && !hit) begin
        n   = LenW'(2*AddrW-1-i);
        hit = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

// ----- hdl/aprt_cell.sv -----
// One slot of the prefix table, held as a stage of a rotating chain.
// Depends on aprt_pkg.
module aprt_cell (
  input  logic                                clk_i,
  input  aprt_pkg::cell_ctrl_t                ctrl_i,
  input  logic                                head_i,
  input  logic                                used_i,
  input  logic [2*aprt_pkg::AddrW-1:0]        addr_i,
  input  logic [aprt_pkg::LenW-1:0]           len_i,
  input  logic [2*aprt_pkg::AddrW-1:0]        req_addr_i,
  input  logic [aprt_pkg::LenW-1:0]           req_len_i,
  input  logic                                rst_ni,
  output logic                                used_o,
  output logic [2*aprt_pkg::AddrW-1:0]        addr_o,
  output logic [aprt_pkg::LenW-1:0]           len_o
);
  import aprt_pkg::*;

  logic                 used_q, used_d;
  logic [2*AddrW-1:0]   addr_q, addr_d;
  logic [LenW-1:0]      len_q, len_d;

  // Take the neighbor's content on shift; the head cell may be cleared or written.
  always_comb begin
    used_d = used_q;
    addr_d = addr_q;
    len_d  = len_q;
    if (ctrl_i.shift) begin
      used_d = used_i;
      addr_d = addr_i;
      len_d  = len_i;
    end
    if (head_i && ctrl_i.clear) used_d = 1'b0;
    if (head_i && ctrl_i.write) begin
      used_d = 1'b1;
      addr_d = req_addr_i;
      len_d  = req_len_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) used_q <= 1'b0;
    else         used_q <= used_d;
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    len_q  <= len_d;
  end

  assign used_o = used_q;
  assign addr_o = addr_q;
  assign len_o  = len_q;

endmodule

// ----- hdl/allowed_prefix_route_table_unit.sv -----
// Top level of the allowed prefix route table: sequencer plus a ring of slot cells.
// Depends on aprt_pkg and aprt_cell.
//
// Every slot lives in a ring of cells that rotates one position per cycle while
// a request is scanned or written; the sequencer inspects the cell at the ring
// head (index 0), and a clear or a write lands in the last cell, which takes the
// head content on the same edge. A request's scan spans one full revolution of
// the ring, set by the single compare at the head, and its result is then
// registered. Add prefix checks for a duplicate, and the first free slot, in one
// revolution, then writes during a second one. The result sits in an output
// register. The sequencer then returns to idle, where the next request can be
// taken even while that result still waits; the result of the next request is
// held back until the previous one is delivered. A new request is taken only
// once the previous one has finished its revolutions.
module allowed_prefix_route_table_unit #(
  parameter int PEER_COUNT     = 4,
  parameter int SLOTS_PER_PEER = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   req_type_i,
  input  logic [1:0]                   peer_sel_i,
  input  logic [63:0]                  addr_high_i,
  input  logic [63:0]                  addr_low_i,
  input  logic [7:0]                   prefix_bits_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   status_o,
  output logic [1:0]                   route_peer_o,
  output logic [7:0]                   matched_bits_o
);
  import aprt_pkg::*;

  localparam int Total = PEER_COUNT * SLOTS_PER_PEER;
  localparam int IdxW  = (Total > 1) ? $clog2(Total) : 1;
  localparam int PeerW = (PEER_COUNT > 1) ? $clog2(PEER_COUNT) : 1;
  localparam int SlotW = (SLOTS_PER_PEER > 1) ? $clog2(SLOTS_PER_PEER) : 1;
  localparam int CntW  = $clog2(Total + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_WRITE = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Captured request
  logic [1:0]         req_q;
  logic [1:0]         peer_q;
  logic [2*AddrW-1:0] addr_q;
  logic [LenW-1:0]    len_q;

  // Head position: number of rotations so far in this revolution
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [PEER_COUNT-1:0] peer_on_q, peer_on_d;

  // Peer and slot of the head cell, advanced with the rotation
  logic [PeerW-1:0]   head_peer_q, head_peer_d;
  logic [SlotW-1:0]   head_slot_q, head_slot_d;
  logic [PeerW-1:0]   peer_nxt;
  logic [SlotW-1:0]   slot_nxt;

  // Scan results
  logic               found_q, found_d;
  logic               stop_q, stop_d;
  logic [LenW-1:0]    best_q, best_d;
  logic [PeerW-1:0]   bpeer_q, bpeer_d;
  logic               dup_q, dup_d;
  logic               free_q, free_d;
  logic [IdxW-1:0]    free_idx_q, free_idx_d;

  logic               ovalid_q;
  logic [1:0]         status_q, route_q;
  logic [LenW-1:0]    mbits_q;

  // Ring wiring
  logic                 used_w [Total];
  logic [2*AddrW-1:0]   addr_w [Total];
  logic [LenW-1:0]      len_w  [Total];
  cell_ctrl_t           ctrl;

  logic [IdxW-1:0]    head_idx;
  logic [PeerW-1:0]   head_peer;
  logic [PeerW-1:0]   sel_peer;
  logic               peer_ok;
  logic               in_acc, out_acc;
  logic [LenW-1:0]    m;

  // The last cell receives the head content, so clears and writes land there
  genvar g;
  generate
    for (g = 0; g < Total; g++) begin : g_cell
      aprt_cell u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .ctrl_i     (ctrl),
        .head_i     (g == Total - 1),
        .used_i     (used_w[(g + 1) % Total]),
        .addr_i     (addr_w[(g + 1) % Total]),
        .len_i      (len_w[(g + 1) % Total]),
        .req_addr_i (addr_q),
        .req_len_i  (len_q),
        .used_o     (used_w[g]),
        .addr_o     (addr_w[g]),
        .len_o      (len_w[g])
      );
    end
  endgenerate

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = ovalid_q && !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);

  // Slot index at the head: rotation count since the ring was aligned
  assign head_idx  = cnt_q[IdxW-1:0];
  assign head_peer = head_peer_q;
  assign sel_peer  = PeerW'(peer_q);
  assign peer_ok   = (32'(peer_q) < PEER_COUNT);
  assign m         = common_lead(addr_w[0], addr_q);

  // Step the head peer and slot by one position
  always_comb begin
    if (head_slot_q == SlotW'(SLOTS_PER_PEER - 1)) begin
      slot_nxt = '0;
      peer_nxt = head_peer_q + PeerW'(1);
    end else begin
      slot_nxt = head_slot_q + SlotW'(1);
      peer_nxt = head_peer_q;
    end
  end

  // Sequence each request over one ring revolution, or two for an add that writes
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    head_peer_d = head_peer_q;
    head_slot_d = head_slot_q;
    peer_on_d   = peer_on_q;
    found_d     = found_q;
    stop_d      = stop_q;
    best_d      = best_q;
    bpeer_d     = bpeer_q;
    dup_d       = dup_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    ctrl        = '0;
    case (state_q)
      S_IDLE: begin
        cnt_d       = '0;
        head_peer_d = '0;
        head_slot_d = '0;
        found_d     = 1'b0;
        stop_d      = 1'b0;
        best_d      = '0;
        bpeer_d     = '0;
        dup_d       = 1'b0;
        free_d      = 1'b0;
        if (in_acc) state_d = S_SCAN;
      end
      S_SCAN: begin
        ctrl.shift  = 1'b1;
        cnt_d       = cnt_q + CntW'(1);
        head_peer_d = peer_nxt;
        head_slot_d = slot_nxt;
        case (req_q)
          REQ_ENABLE, REQ_REMOVE: begin
            if (peer_ok && head_peer == sel_peer) ctrl.clear = 1'b1;
          end
          REQ_ADD: begin
            if (peer_ok && head_peer == sel_peer) begin
              if (used_w[0] && addr_w[0] == addr_q && len_w[0] == len_q)
                dup_d = 1'b1;
              if (!used_w[0] && !free_q) begin
                free_d     = 1'b1;
                free_idx_d = head_idx;
              end
            end
          end
          default: begin
            if (!stop_q && peer_on_q[head_peer] && used_w[0] && m >= len_w[0]) begin
              if (m > best_q || best_q == '0) begin
                best_d  = m;
                bpeer_d = head_peer;
                found_d = 1'b1;
              end
              if (m == FullLen) stop_d = 1'b1;
            end
          end
        endcase
        if (cnt_q == CntW'(Total - 1)) begin
          cnt_d       = '0;
          head_peer_d = '0;
          head_slot_d = '0;
          if (req_q == REQ_ENABLE && peer_ok) peer_on_d[sel_peer] = 1'b1;
          if (req_q == REQ_REMOVE && peer_ok) peer_on_d[sel_peer] = 1'b0;
          if (req_q == REQ_ADD && !dup_d && free_d) state_d = S_WRITE;
          else                                      state_d = S_DONE;
        end
      end
      S_WRITE: begin
        // Rotate a full revolution; load the free slot as it passes the head
        if (head_idx == free_idx_q) ctrl.write = 1'b1;
        ctrl.shift  = 1'b1;
        cnt_d       = cnt_q + CntW'(1);
        head_peer_d = peer_nxt;
        head_slot_d = slot_nxt;
        if (cnt_q == CntW'(Total - 1)) begin
          cnt_d       = '0;
          head_peer_d = '0;
          head_slot_d = '0;
          state_d     = S_DONE;
        end
      end
      S_DONE: begin
        if (!ovalid_q || out_acc) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      head_peer_q <= '0;
      head_slot_q <= '0;
      peer_on_q   <= '0;
      found_q     <= 1'b0;
      stop_q      <= 1'b0;
      dup_q       <= 1'b0;
      free_q      <= 1'b0;
      ovalid_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      head_peer_q <= head_peer_d;
      head_slot_q <= head_slot_d;
      peer_on_q   <= peer_on_d;
      found_q     <= found_d;
      stop_q      <= stop_d;
      dup_q       <= dup_d;
      free_q      <= free_d;
      if (state_q == S_DONE && state_d == S_IDLE) ovalid_q <= 1'b1;
      else if (out_acc)                           ovalid_q <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    best_q     <= best_d;
    bpeer_q    <= bpeer_d;
    free_idx_q <= free_idx_d;
    if (in_acc) begin
      req_q  <= req_type_i;
      peer_q <= peer_sel_i;
      addr_q <= {addr_high_i, addr_low_i};
      len_q  <= prefix_bits_i;
    end
    if (state_q == S_DONE && state_d == S_IDLE) begin
      route_q <= 2'd0;
      mbits_q <= '0;
      case (req_q)
        REQ_ADD:    status_q <= (dup_q || free_q) ? ST_OK : ST_FULL;
        REQ_LOOKUP: begin
          if (found_q) begin
            status_q <= ST_OK;
            route_q  <= 2'(bpeer_q);
            mbits_q  <= best_q;
          end else begin
            status_q <= ST_NOROUTE;
          end
        end
        default:    status_q <= ST_OK;
      endcase
    end
  end

  assign out_valid_o    = ovalid_q;
  assign status_o       = status_q;
  assign route_peer_o   = route_q;
  assign matched_bits_o = mbits_q;

  // A new request is only taken with the sequencer idle
  a_idle_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> state_q == S_IDLE)
    else $error("request taken while busy");

  // The ring is aligned whenever the sequencer is idle
  a_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> cnt_q == '0)
    else $error("ring misaligned at idle");

  // A write happens only when a free slot was found
  a_write_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WRITE |-> free_q && !dup_q)
    else $error("write without free slot");

endmodule
